// ===== hw/rtl/lqd_pkg.sv =====
// Shared types, constants and segment table for the quarter-duty LCD driver.
`timescale 1ns / 1ps

package lqd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int PINS_W   = 9;
    localparam int NUM_COM  = 4;
    localparam int NUM_BYTE = 5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PINS_W-1:0]   pins_t;
    typedef logic [1:0]          level_t;
    typedef logic [2:0]          phase_t;
    typedef logic [3:0]          digit_t;
    typedef logic [7:0]          byte_t;
    typedef byte_t               disp_t [NUM_BYTE];

    localparam level_t LEVEL_HALF = 2'd0;
    localparam level_t LEVEL_LOW  = 2'd1;
    localparam level_t LEVEL_HIGH = 2'd2;

    function automatic byte_t seg_code(input digit_t d);
        byte_t code;
        unique case (d)
            4'h0: code = 8'h7B;
            4'h1: code = 8'h30;
            4'h2: code = 8'h5D;
            4'h3: code = 8'h75;
            4'h4: code = 8'h36;
            4'h5: code = 8'h67;
            4'h6: code = 8'h6F;
            4'h7: code = 8'h31;
            4'h8: code = 8'h7F;
            4'h9: code = 8'h77;
            4'hA: code = 8'h3F;
            4'hB: code = 8'h6E;
            4'hC: code = 8'h4C;
            4'hD: code = 8'h7C;
            4'hE: code = 8'h4F;
            4'hF: code = 8'h0F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/lqd_sample_if.sv =====
// Valid/ready channel carrying one frame tick with its sample.
`timescale 1ns / 1ps

interface lqd_sample_if;
    import lqd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/lqd_result_if.sv =====
// Valid/ready channel carrying common levels and segment pins for one tick.
`timescale 1ns / 1ps

interface lqd_result_if;
    import lqd_pkg::*;

    logic   valid;
    logic   ready;
    level_t com0_level;
    level_t com1_level;
    level_t com2_level;
    level_t com3_level;
    pins_t  segment_pins;

    modport source (output valid, output com0_level, output com1_level, output com2_level,
                    output com3_level, output segment_pins, input ready);
    modport sink   (input valid, input com0_level, input com1_level, input com2_level,
                    input com3_level, input segment_pins, output ready);
endinterface

// ===== hw/rtl/lcd_quarter_duty_digit_driver_top.sv =====
// Top level: 1/4 duty, 1/2 bias LCD driver for four commons and nine segment pins.
`timescale 1ns / 1ps

// Each transfer on sample_ch is one frame tick; eight ticks make a frame. Tick 0
// captures the sample, splits it into four digits (decimal, or hex with a leading
// zero when hex_mode is set) and loads the segment buffer; later ticks invert or
// rotate-and-invert it. One result follows each tick in the cycle after its transfer,
// held in the output register until taken. The block takes one tick per clock;
// the digit split and buffer update are combinational logic ahead of that register,
// so ticks stall only while a finished result waits and result_ch is not ready.
// cfg_we writes hex_mode from cfg_wdata; write it only while the block is idle.
module lcd_quarter_duty_digit_driver_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    lqd_sample_if.sink        sample_ch,
    lqd_result_if.source      result_ch
);
    import lqd_pkg::*;

    logic   hex_mode_reg;
    phase_t phase_reg;
    phase_t phase_next;
    disp_t  bytes_reg;
    disp_t  bytes_next;
    logic   out_valid_reg;
    level_t com_reg [NUM_COM];
    level_t com_next [NUM_COM];
    pins_t  pins_reg;
    pins_t  pins_next;

    logic   take;
    digit_t dig [NUM_COM];
    digit_t thou;
    digit_t hund;
    digit_t tens;
    logic [9:0] rem1;
    logic [6:0] rem2;
    logic [3:0] rem3;

    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign take            = sample_ch.valid && sample_ch.ready;
    assign phase_next      = phase_reg + 3'd1;

    // Decimal split: one compare/subtract level per digit.
    always_comb
    begin
        thou = 4'd0;
        if (sample_ch.sample >= 12'd1000) thou = 4'd1;
        if (sample_ch.sample >= 12'd2000) thou = 4'd2;
        if (sample_ch.sample >= 12'd3000) thou = 4'd3;
        if (sample_ch.sample >= 12'd4000) thou = 4'd4;
        rem1 = 10'(sample_ch.sample - 12'(thou) * 12'd1000);

        hund = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem1 >= 10'(k * 100)) hund = 4'(k);
        end
        rem2 = 7'(rem1 - 10'(hund) * 10'd100);

        tens = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem2 >= 7'(k * 10)) tens = 4'(k);
        end
        rem3 = 4'(rem2 - 7'(tens) * 7'd10);

        if (hex_mode_reg)
        begin
            dig[0] = 4'd0;
            dig[1] = sample_ch.sample[11:8];
            dig[2] = sample_ch.sample[7:4];
            dig[3] = sample_ch.sample[3:0];
        end
        else
        begin
            dig[0] = thou;
            dig[1] = hund;
            dig[2] = tens;
            dig[3] = rem3;
        end
    end

    always_comb
    begin
        byte_t v;
        v = 8'h00;
        for (int i = 0; i < NUM_BYTE; i++)
        begin
            v = phase_reg[0] ? bytes_reg[i] : {bytes_reg[i][0], bytes_reg[i][7:1]};
            bytes_next[i] = ~v;
        end
        if (phase_reg == 3'd0)
        begin
            for (int i = 0; i < NUM_COM; i++)
            begin
                bytes_next[i] = seg_code(dig[i]);
            end
            bytes_next[NUM_BYTE-1] = 8'h00;
        end

        for (int i = 0; i < NUM_COM; i++)
        begin
            pins_next[2*i]     = bytes_next[i][0];
            pins_next[2*i + 1] = bytes_next[i][4];
            com_next[i] = (phase_reg[2:1] == 2'(i))
                          ? (phase_reg[0] ? LEVEL_HIGH : LEVEL_LOW) : LEVEL_HALF;
        end
        pins_next[PINS_W-1] = bytes_next[NUM_BYTE-1][0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_mode_reg  <= 1'b0;
            phase_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BYTE; i++)
            begin
                bytes_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                hex_mode_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg     <= phase_next;
                bytes_reg     <= bytes_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            com_reg  <= com_next;
            pins_reg <= pins_next;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.com0_level   = com_reg[0];
    assign result_ch.com1_level   = com_reg[1];
    assign result_ch.com2_level   = com_reg[2];
    assign result_ch.com3_level   = com_reg[3];
    assign result_ch.segment_pins = pins_reg;

`ifndef SYNTHESIS
    a_one_common: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({com_reg[0] != LEVEL_HALF, com_reg[1] != LEVEL_HALF,
                                   com_reg[2] != LEVEL_HALF, com_reg[3] != LEVEL_HALF}))
        else $error("result does not drive exactly one common");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> phase_reg == 3'($past(phase_reg) + 3'd1))
        else $error("frame phase did not advance by one per transfer");

    a_load_clears_extra: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == 3'd0) |=> (bytes_reg[NUM_BYTE-1] == 8'h00 && !pins_reg[PINS_W-1]))
        else $error("phase zero load did not clear the extra byte");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ch.ready)
        else $error("tick stalled with empty output register");
`endif

endmodule

// ===== bench/lcd_quarter_duty_digit_driver_top_tb.sv =====
// Self-checking testbench for the quarter-duty LCD digit driver.
`timescale 1ns / 1ps

module lcd_quarter_duty_digit_driver_top_tb;
    import lqd_pkg::*;

    localparam bit MODE_DEC = 1'b0;
    localparam bit MODE_HEX = 1'b1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int TICKS_PER_PHASE = 230;
    localparam int LONG_HOLD_CYCLES = 120;

    typedef struct packed {
        level_t com0_level;
        level_t com1_level;
        level_t com2_level;
        level_t com3_level;
        pins_t  segment_pins;
    } drive_t;

    typedef struct packed {
        bit      hex;
        sample_t sample;
        bit      typed;
        drive_t  want;
    } tick_row_t;

    localparam drive_t UNTYPED = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    lqd_sample_if sample_ch ();
    lqd_result_if result_ch ();

    lcd_quarter_duty_digit_driver_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    byte_t digit_segments [16] = '{
        8'h7B, 8'h30, 8'h5D, 8'h75, 8'h36, 8'h67, 8'h6F, 8'h31,
        8'h7F, 8'h77, 8'h3F, 8'h6E, 8'h4C, 8'h7C, 8'h4F, 8'h0F
    };

    sample_t corner_samples [10] = '{
        12'd9, 12'd10, 12'd99, 12'd100, 12'd999,
        12'd1000, 12'd1999, 12'd2000, 12'd3999, 12'd4000
    };

    // Three full frames and the first tick of a fourth: decimal zero, decimal full scale, hex full scale, hex letters.
    tick_row_t directed_ticks [25] = '{
        '{MODE_DEC, 12'd0,    1'b1, '{LEVEL_LOW,  LEVEL_HALF, LEVEL_HALF, LEVEL_HALF, 9'h0FF}},
        '{MODE_DEC, 12'hFFF,  1'b1, '{LEVEL_HIGH, LEVEL_HALF, LEVEL_HALF, LEVEL_HALF, 9'h100}},
        '{MODE_DEC, 12'hAAA,  1'b0, UNTYPED},
        '{MODE_DEC, 12'h555,  1'b0, UNTYPED},
        '{MODE_DEC, 12'h000,  1'b0, UNTYPED},
        '{MODE_DEC, 12'hFFF,  1'b0, UNTYPED},
        '{MODE_DEC, 12'h001,  1'b0, UNTYPED},
        '{MODE_DEC, 12'h800,  1'b0, UNTYPED},
        '{MODE_DEC, 12'd4095, 1'b1, '{LEVEL_LOW,  LEVEL_HALF, LEVEL_HALF, LEVEL_HALF, 9'h07E}},
        '{MODE_DEC, 12'd1000, 1'b0, UNTYPED},
        '{MODE_DEC, 12'd999,  1'b0, UNTYPED},
        '{MODE_DEC, 12'h123,  1'b0, UNTYPED},
        '{MODE_DEC, 12'hFED,  1'b0, UNTYPED},
        '{MODE_DEC, 12'd7,    1'b0, UNTYPED},
        '{MODE_DEC, 12'h400,  1'b0, UNTYPED},
        '{MODE_DEC, 12'd100,  1'b0, UNTYPED},
        '{MODE_HEX, 12'd4095, 1'b1, '{LEVEL_LOW,  LEVEL_HALF, LEVEL_HALF, LEVEL_HALF, 9'h057}},
        '{MODE_HEX, 12'h000,  1'b0, UNTYPED},
        '{MODE_HEX, 12'hFFF,  1'b0, UNTYPED},
        '{MODE_HEX, 12'h5A5,  1'b0, UNTYPED},
        '{MODE_HEX, 12'hA5A,  1'b0, UNTYPED},
        '{MODE_HEX, 12'h0F0,  1'b0, UNTYPED},
        '{MODE_HEX, 12'hF0F,  1'b0, UNTYPED},
        '{MODE_HEX, 12'h321,  1'b0, UNTYPED},
        '{MODE_HEX, 12'hABC,  1'b0, UNTYPED}
    };

    disp_t  lcd_bytes = '{default: '0};
    phase_t tick_phase = '0;
    bit     hex_mode_shadow = MODE_DEC;

    drive_t expected_drive_q [$];
    drive_t next_drive;
    int     fail_count = 0;
    int     burst_left = 1;
    int     idle_cycles = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     rx_cycle = 0;
    int     rx_style = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic compute_drive(input sample_t s, output drive_t d);
        int unsigned v;
        int unsigned digit [4];
        byte_t b;
        level_t lvl;
        pins_t pins;
        v = s;
        if (tick_phase == 3'd0)
        begin
            if (hex_mode_shadow == MODE_HEX)
            begin
                digit[0] = 0;
                digit[1] = (v >> 8) & 4'hF;
                digit[2] = (v >> 4) & 4'hF;
                digit[3] = v & 4'hF;
            end
            else
            begin
                digit[0] = v / 1000;
                digit[1] = (v % 1000) / 100;
                digit[2] = (v % 100) / 10;
                digit[3] = v % 10;
            end
            for (int i = 0; i < 4; i++)
                lcd_bytes[i] = digit_segments[digit[i]];
            lcd_bytes[4] = '0;
        end
        else
        begin
            for (int i = 0; i < NUM_BYTE; i++)
            begin
                b = lcd_bytes[i];
                if (!tick_phase[0])
                    b = {b[0], b[7:1]};
                lcd_bytes[i] = ~b;
            end
        end
        pins = '0;
        for (int i = 0; i < 4; i++)
        begin
            pins[2*i]   = lcd_bytes[i][0];
            pins[2*i+1] = lcd_bytes[i][4];
        end
        pins[8] = lcd_bytes[4][0];
        lvl = tick_phase[0] ? LEVEL_HIGH : LEVEL_LOW;
        d.com0_level   = (tick_phase[2:1] == 2'd0) ? lvl : LEVEL_HALF;
        d.com1_level   = (tick_phase[2:1] == 2'd1) ? lvl : LEVEL_HALF;
        d.com2_level   = (tick_phase[2:1] == 2'd2) ? lvl : LEVEL_HALF;
        d.com3_level   = (tick_phase[2:1] == 2'd3) ? lvl : LEVEL_HALF;
        d.segment_pins = pins;
        tick_phase = tick_phase + 3'd1;
    endtask

    // Drives one tick, waits for its transfer, records the expectation, then either
    // keeps valid high for the next tick or drops it, after the last tick or for a gap.
    task automatic offer_tick(input sample_t s, input bit typed, input drive_t want,
                              input bit last);
        drive_t d;
        int gap;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        compute_drive(s, d);
        expected_drive_q.push_back(typed ? want : d);
        burst_left--;
        if (last)
        begin
            sample_ch.valid <= 1'b0;
        end
        else if (burst_left <= 0)
        begin
            sample_ch.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        hex_mode_shadow = m;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_drive_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                fail_count++;
            end
            else
            begin
                next_drive = expected_drive_q.pop_front();
                check_field("com0_level", next_drive.com0_level, result_ch.com0_level);
                check_field("com1_level", next_drive.com1_level, result_ch.com1_level);
                check_field("com2_level", next_drive.com2_level, result_ch.com2_level);
                check_field("com3_level", next_drive.com3_level, result_ch.com3_level);
                check_field("segment_pins", next_drive.segment_pins,
                            result_ch.segment_pins);
            end
        end
    end

    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 400 == 0)
            rx_style = $urandom_range(0, 3);
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= $urandom_range(0, 1);
                2:       result_ch.ready <= ($urandom_range(0, 9) != 0);
                default: result_ch.ready <= ((rx_cycle % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        bit last;
        bit mode;
        sample_t s;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(MODE_DEC);

        for (int i = 0; i < 25; i++)
        begin
            if (directed_ticks[i].hex != hex_mode_shadow)
            begin
                wait_drained();
                write_mode(directed_ticks[i].hex);
            end
            last = (i == 24) || (directed_ticks[i+1].hex != directed_ticks[i].hex);
            offer_tick(directed_ticks[i].sample, directed_ticks[i].typed,
                       directed_ticks[i].want, last);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            mode = (ph < 4) ? ((ph % 2 == 0) ? MODE_HEX : MODE_DEC) : $urandom_range(0, 1);
            write_mode(mode);
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (ph == 2 && n == 40)
                    hold_req = 1'b1;
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    s = '0;
                else if (kind == 1)
                    s = 12'hFFF;
                else if (kind == 2)
                    s = corner_samples[$urandom_range(0, 9)];
                else
                    s = $urandom_range(0, 4095);
                last = (n == TICKS_PER_PHASE - 1) || (ph == 3 && n == 115);
                offer_tick(s, 1'b0, UNTYPED, last);
                if (ph == 3 && n == 115)
                    wait_drained();
            end
        end

        while (expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== lcd_quarter_duty_digit_driver_top.f =====
hw/rtl/lqd_pkg.sv
hw/rtl/lqd_sample_if.sv
hw/rtl/lqd_result_if.sv
hw/rtl/lcd_quarter_duty_digit_driver_top.sv
bench/lcd_quarter_duty_digit_driver_top_tb.sv
